@@ hdl/dwvp_pkg.sv @@
// ----------------------------------------------------------------------------
// dwvp_pkg: shared types and constants
// Payload structs, register indexes and fixed-point constants of the
// dual-wheel velocity PID controller.
// ----------------------------------------------------------------------------
package dwvp_pkg;

  localparam int OUTPUT_LIMIT = 5012;
  localparam int COUNT_WRAP   = 2049;
  localparam int COUNT_HALF   = (COUNT_WRAP - 1) / 2;

  localparam logic [31:0] DIST_PER_COUNT_Q24 = 32'd276565;
  localparam logic [31:0] VEL_PER_COUNT_Q12  = 32'd270083;
  localparam logic signed [63:0] LIM_Q12 = 64'(OUTPUT_LIMIT) * 64'd4096;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DERIV = 3'd2;
  localparam logic [2:0] REG_ACCEL = 3'd3;
  localparam logic [2:0] REG_EN    = 3'd4;

  typedef struct packed {
    logic               mode;
    logic               wheel_sel;
    logic [11:0]        right_count;
    logic [11:0]        left_count;
    logic signed [31:0] target_velocity;
    logic signed [31:0] target_distance;
    logic [30:0]        brake_distance;
    logic signed [31:0] brake_velocity;
    logic               arm_brake;
  } in_item_t;

  typedef struct packed {
    logic [10:0] right_duty;
    logic        right_forward;
    logic [10:0] left_duty;
    logic        left_forward;
    logic        brake_fired;
  } out_item_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (x < -64'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

@@ hdl/dual_wheel_velocity_pid.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_velocity_pid: two-wheel incremental PID velocity controller
// Sequencer around one shared 33x33 signed multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i) carries control ticks
//   and move commands. A command transaction updates one wheel's targets
//   and produces nothing. A control tick runs a fixed sequence of
//   31 steps around the shared multiplier (count scaling, brake check, ramp,
//   errors, three gain products per wheel, clamp and duty) and ends with one
//   transaction on the output channel (out_valid_o/out_ready_i, out_data_o).
//   The sequencer takes one step per cycle while its output steps are not
//   held, and it accepts a new tick or command only while it is idle.
//   The result sits in an output register, so the next item is accepted as
//   soon as the sequencer is idle, even while the result is stalled; a new
//   tick waits in its output steps only if the previous result is still held.
//   Reset (rst_ni low, asynchronous) returns all state and the configuration
//   to reset values, but not the datapath registers. Configuration writes go
//   through cfg_we_i, cfg_idx_i and cfg_data_i and take effect immediately.
// ----------------------------------------------------------------------------
module dual_wheel_velocity_pid
  import dwvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // Sequencer steps.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DM    = 5'd1;  // distance product, per wheel
  localparam logic [4:0] S_DA    = 5'd2;
  localparam logic [4:0] S_VM    = 5'd3;  // velocity product
  localparam logic [4:0] S_VA    = 5'd4;
  localparam logic [4:0] S_BRK   = 5'd5;
  localparam logic [4:0] S_RAMP  = 5'd6;  // per wheel from here on
  localparam logic [4:0] S_ERR   = 5'd7;
  localparam logic [4:0] S_WSUM  = 5'd8;
  localparam logic [4:0] S_PM    = 5'd9;
  localparam logic [4:0] S_PA    = 5'd10;
  localparam logic [4:0] S_IM    = 5'd11;
  localparam logic [4:0] S_IA    = 5'd12;
  localparam logic [4:0] S_DFM   = 5'd13;
  localparam logic [4:0] S_DFA   = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0]  state_q, state_d;
  logic        wh_q, wh_d;

  // Configuration registers.
  logic [31:0] kp_q, ki_q, kd_q;
  logic [9:0]  accel_q;
  logic        en_q;

  // Controller state.
  logic signed [31:0] dist_q [2];
  logic signed [31:0] vh_q   [8];
  logic signed [31:0] ramp_q [2];
  logic signed [31:0] eh_q   [8];
  logic signed [31:0] wsum_q [2];
  logic signed [31:0] pid_q  [2];
  logic signed [31:0] mt_q   [8];
  logic               arm_q  [2];

  in_item_t           item_q;
  logic               fired_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] diff_q;
  out_item_t          res_q, res_d;
  logic               ovalid_q;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic [11:0]        raw;
  logic signed [12:0] cnt_dec;
  logic [2:0]         b4;
  logic signed [63:0] cur, step, avg, tgt, dsum, rounded, lim_v, mag;
  logic signed [31:0] pclamp;
  logic [31:0]        duty_full;
  logic [10:0]        duty;
  logic               out_go;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;
  assign out_go      = !ovalid_q || out_ready_i;

  assign b4      = {wh_q, 2'b00};
  assign raw     = wh_q ? item_q.left_count : item_q.right_count;
  assign cnt_dec = (raw > 12'(COUNT_HALF)) ? 13'($signed({1'b0, raw}) - 13'(COUNT_WRAP))
                                           : $signed({1'b0, raw});

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DM: begin
        mul_a = 33'(cnt_dec);
        mul_b = $signed({1'b0, DIST_PER_COUNT_Q24});
      end
      S_VM: begin
        mul_a = 33'(cnt_dec);
        mul_b = $signed({1'b0, VEL_PER_COUNT_Q12});
      end
      S_PM: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = 33'(eh_q[b4]);
      end
      S_IM: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = 33'(wsum_q[wh_q]);
      end
      S_DFM: begin
        mul_a = $signed({1'b0, kd_q});
        mul_b = 33'(diff_q);
      end
      default: ;
    endcase
  end
  assign mul_p   = mul_a * mul_b;
  assign rounded = (prod_q + 64'sd8388608) >>> 24;

  // Ramp and error helpers.
  assign tgt  = 64'(mt_q[b4]);
  assign step = 64'(accel_q) * 64'sd1024;
  always_comb begin
    cur = 64'(ramp_q[wh_q]);
    if (tgt > cur) begin
      cur = cur + step;
      if (cur > tgt) cur = tgt;
    end else if (tgt < cur) begin
      cur = cur - step;
      if (cur < tgt) cur = tgt;
    end
  end
  assign dsum = 64'(vh_q[b4]) + 64'(vh_q[b4 + 3'd1]) + 64'(vh_q[b4 + 3'd2])
              + 64'(vh_q[b4 + 3'd3]);
  assign avg  = dsum >>> 2;

  // Clamp and duty for the current wheel.
  assign lim_v = LIM_Q12;
  always_comb begin
    pclamp = pid_q[wh_q];
    if (en_q) begin
      if (64'(pclamp) > lim_v) pclamp = 32'(lim_v);
      if (64'(pclamp) < -lim_v) pclamp = 32'(-lim_v);
    end
    mag = (pclamp < 0) ? -64'(pclamp) : 64'(pclamp);
    // Divide by 3*4096: shift by 12, then by 3 via reciprocal.
    duty_full = 32'((64'(mag[31:12]) * 64'd43691) >> 17);
    duty = (duty_full > 32'd2047) ? 11'd2047 : duty_full[10:0];
  end

  always_comb begin
    res_d = res_q;
    if (wh_q) begin
      res_d.left_duty    = en_q ? duty : 11'd0;
      res_d.left_forward = en_q ? !(pclamp > 0) : 1'b0;
    end else begin
      res_d.right_duty    = en_q ? duty : 11'd0;
      res_d.right_forward = en_q ? (pclamp > 0) : 1'b0;
    end
    res_d.brake_fired = fired_q;
  end

  // Next-step logic.
  always_comb begin
    state_d = state_q;
    wh_d    = wh_q;
    case (state_q)
      S_IDLE: if (in_valid_i && !in_data_i.mode) begin
        state_d = S_DM;
        wh_d    = 1'b0;
      end
      S_DM:  state_d = S_DA;
      S_DA:  state_d = S_VM;
      S_VM:  state_d = S_VA;
      S_VA: begin
        if (wh_q) begin
          state_d = S_BRK;
          wh_d    = 1'b0;
        end else begin
          state_d = S_DM;
          wh_d    = 1'b1;
        end
      end
      S_BRK:  state_d = S_RAMP;
      S_RAMP: state_d = S_ERR;
      S_ERR:  state_d = S_WSUM;
      S_WSUM: state_d = S_PM;
      S_PM:   state_d = S_PA;
      S_PA:   state_d = S_IM;
      S_IM:   state_d = S_IA;
      S_IA:   state_d = S_DFM;
      S_DFM:  state_d = S_DFA;
      S_DFA:  state_d = S_FIN;
      S_FIN: begin
        if (wh_q) begin
          state_d = S_OUT;
          wh_d    = 1'b0;
        end else begin
          state_d = S_RAMP;
          wh_d    = 1'b1;
        end
      end
      S_OUT: begin
        if (out_go) begin
          state_d = (wh_q) ? S_IDLE : S_OUT;
          wh_d    = !wh_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wh_q     <= 1'b0;
      ovalid_q <= 1'b0;
      kp_q     <= 32'd10066330;
      ki_q     <= 32'd336;
      kd_q     <= 32'd10905190;
      accel_q  <= 10'd5;
      en_q     <= 1'b1;
      fired_q  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        dist_q[i] <= '0;
        ramp_q[i] <= '0;
        wsum_q[i] <= '0;
        pid_q[i]  <= '0;
        arm_q[i]  <= 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
        vh_q[i] <= '0;
        eh_q[i] <= '0;
        mt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      wh_q    <= wh_d;

      // The result becomes valid at the last output step and clears when taken.
      if (state_q == S_OUT && wh_q && out_go) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP:  kp_q    <= cfg_data_i;
          REG_INTEG: ki_q    <= cfg_data_i;
          REG_DERIV: kd_q    <= cfg_data_i;
          REG_ACCEL: accel_q <= cfg_data_i[9:0];
          REG_EN:    en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: if (in_valid_i && in_data_i.mode) begin
          mt_q[{in_data_i.wheel_sel, 2'b00}] <= in_data_i.target_velocity;
          mt_q[{in_data_i.wheel_sel, 2'b01}] <= in_data_i.target_distance;
          mt_q[{in_data_i.wheel_sel, 2'b10}] <= $signed({1'b0, in_data_i.brake_distance});
          mt_q[{in_data_i.wheel_sel, 2'b11}] <= in_data_i.brake_velocity;
          arm_q[in_data_i.wheel_sel]         <= in_data_i.arm_brake;
        end else if (in_valid_i) begin
          fired_q <= 1'b0;
        end
        S_DA: dist_q[wh_q] <= sat32(64'(dist_q[wh_q]) + ((prod_q + 64'sd2048) >>> 12));
        S_VA: begin
          vh_q[b4 + 3'd3] <= vh_q[b4 + 3'd2];
          vh_q[b4 + 3'd2] <= vh_q[b4 + 3'd1];
          vh_q[b4 + 3'd1] <= vh_q[b4];
          vh_q[b4]        <= prod_q[31:0];
        end
        S_BRK: begin
          // Right wheel has priority; left is examined only if right unarmed.
          if (arm_q[0]) begin
            if (64'(mt_q[2]) >= ((64'(mt_q[1]) - 64'(dist_q[0])) < 0 ?
                -(64'(mt_q[1]) - 64'(dist_q[0])) : (64'(mt_q[1]) - 64'(dist_q[0])))) begin
              mt_q[0]  <= mt_q[3];
              arm_q[0] <= 1'b0;
              fired_q  <= 1'b1;
            end
          end else if (arm_q[1]) begin
            if (64'(mt_q[6]) >= ((64'(mt_q[5]) - 64'(dist_q[1])) < 0 ?
                -(64'(mt_q[5]) - 64'(dist_q[1])) : (64'(mt_q[5]) - 64'(dist_q[1])))) begin
              mt_q[4]  <= mt_q[7];
              arm_q[1] <= 1'b0;
              fired_q  <= 1'b1;
            end
          end
        end
        S_RAMP: ramp_q[wh_q] <= cur[31:0];
        S_ERR: begin
          eh_q[b4 + 3'd3] <= eh_q[b4 + 3'd2];
          eh_q[b4 + 3'd2] <= eh_q[b4 + 3'd1];
          eh_q[b4 + 3'd1] <= eh_q[b4];
          eh_q[b4]        <= sat32(64'(ramp_q[wh_q]) - avg);
        end
        S_WSUM: begin
          wsum_q[wh_q] <= sat32(64'(eh_q[b4]) + 64'(eh_q[b4 + 3'd1])
                        + 64'(eh_q[b4 + 3'd2]) + 64'(eh_q[b4 + 3'd3]));
        end
        S_FIN: pid_q[wh_q] <= sat32(acc_q);
        S_OUT: if (out_go) begin
          pid_q[wh_q] <= pclamp;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: item_q <= in_data_i;
      S_DM, S_VM, S_PM, S_IM, S_DFM: prod_q <= mul_p[63:0];
      S_WSUM: begin
        acc_q  <= 64'(pid_q[wh_q]);
        diff_q <= sat32((64'(eh_q[b4]) - 64'(eh_q[b4 + 3'd3]))
                  + 64'sd3 * (64'(eh_q[b4 + 3'd1]) - 64'(eh_q[b4 + 3'd2])));
      end
      S_PA, S_IA, S_DFA: acc_q <= acc_q + rounded;
      S_OUT: if (out_go) res_q <= res_d;
      default: ;
    endcase
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for dual_wheel_velocity_pid
// Drives move commands and control ticks over valid/ready with random
// idling and stalls. A behavioral model of both wheels predicts every tick
// result, and a scoreboard compares the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dwvp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam longint Q12_ONE    = 4096;
  localparam longint LIM_OUT    = longint'(OUTPUT_LIMIT) * Q12_ONE;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = REG_PROP;
  logic [31:0] cfg_data = '0;

  // Controller model state.
  logic [31:0] kp, ki, kd;
  logic [9:0]  accel;
  bit          drive_en;
  longint      dist_acc[2], ramp_vel[2], err_win[2], pid_acc[2];
  longint      vel_hist[2][4], err_hist[2][4];
  longint      tgt_vel[2], tgt_dist[2], brk_dist[2], brk_vel[2];
  bit          brk_arm[2];

  out_item_t   duty_q[$];
  int          mismatches = 0;
  bit          idle_en = 1'b1;
  int          hold_reqs = 0;
  int          hold_done = 0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  dual_wheel_velocity_pid dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Gain product rounded half up from Q8.24 to Q20.12.
  function automatic longint gain_product(logic [31:0] g, longint v);
    longint p;
    p = longint'({32'b0, g}) * v;
    return (p + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic logic [10:0] duty_of(longint o);
    longint mag;
    longint d;
    mag = (o < 0) ? -o : o;
    d = mag / (3 * Q12_ONE);
    return (d > 2047) ? 11'd2047 : d[10:0];
  endfunction

  function automatic void model_reset();
    kp = 32'd10066330;
    ki = 32'd336;
    kd = 32'd10905190;
    accel = 10'd5;
    drive_en = 1'b1;
    for (int w = 0; w < 2; w++) begin
      dist_acc[w] = 0; ramp_vel[w] = 0; err_win[w] = 0; pid_acc[w] = 0;
      tgt_vel[w] = 0; tgt_dist[w] = 0; brk_dist[w] = 0; brk_vel[w] = 0;
      brk_arm[w] = 1'b0;
      for (int k = 0; k < 4; k++) begin
        vel_hist[w][k] = 0;
        err_hist[w][k] = 0;
      end
    end
  endfunction

  function automatic bit brake_hit(int w);
    longint e;
    e = tgt_dist[w] - dist_acc[w];
    if (e < 0) e = -e;
    if (brk_dist[w] >= e) begin
      tgt_vel[w] = brk_vel[w];
      brk_arm[w] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the model by one transaction; returns 1 when a result follows.
  function automatic bit predict_duty(input in_item_t it, output out_item_t r);
    longint q, step, avg, diff, s;
    int     w;
    bit     fired;
    fired = 1'b0;
    r = '0;
    if (it.mode) begin
      w = it.wheel_sel;
      tgt_vel[w]  = longint'(it.target_velocity);
      tgt_dist[w] = longint'(it.target_distance);
      brk_dist[w] = longint'({33'b0, it.brake_distance});
      brk_vel[w]  = longint'(it.brake_velocity);
      brk_arm[w]  = it.arm_brake;
      return 1'b0;
    end
    // Odometry and velocity history.
    for (w = 0; w < 2; w++) begin
      q = (w == 0) ? longint'({52'b0, it.right_count}) : longint'({52'b0, it.left_count});
      if (q > COUNT_HALF) q = q - COUNT_WRAP;
      dist_acc[w] = clip32(dist_acc[w] + ((q * 276565 + 2048) >>> 12));
      for (int k = 3; k > 0; k--) vel_hist[w][k] = vel_hist[w][k-1];
      vel_hist[w][0] = longint'(signed'(32'(q * 270083)));
    end
    // The right brake takes priority over the left one.
    if (brk_arm[0]) fired = brake_hit(0);
    else if (brk_arm[1]) fired = brake_hit(1);
    // Ramp and incremental PID per wheel.
    for (w = 0; w < 2; w++) begin
      step = longint'(accel) * 1024;
      if (tgt_vel[w] > ramp_vel[w]) begin
        ramp_vel[w] += step;
        if (ramp_vel[w] > tgt_vel[w]) ramp_vel[w] = tgt_vel[w];
      end else if (tgt_vel[w] < ramp_vel[w]) begin
        ramp_vel[w] -= step;
        if (ramp_vel[w] < tgt_vel[w]) ramp_vel[w] = tgt_vel[w];
      end
      avg = (vel_hist[w][0] + vel_hist[w][1] + vel_hist[w][2] + vel_hist[w][3]) >>> 2;
      for (int k = 3; k > 0; k--) err_hist[w][k] = err_hist[w][k-1];
      err_hist[w][0] = clip32(ramp_vel[w] - avg);
      err_win[w] = clip32(err_hist[w][0] + err_hist[w][1] + err_hist[w][2] + err_hist[w][3]);
      diff = (err_hist[w][0] - err_hist[w][3]) + 3 * (err_hist[w][1] - err_hist[w][2]);
      s = pid_acc[w] + gain_product(kp, err_hist[w][0]) + gain_product(ki, err_win[w])
          + gain_product(kd, clip32(diff));
      pid_acc[w] = clip32(s);
    end
    if (drive_en) begin
      for (w = 0; w < 2; w++) begin
        if (pid_acc[w] > LIM_OUT) pid_acc[w] = LIM_OUT;
        if (pid_acc[w] < -LIM_OUT) pid_acc[w] = -LIM_OUT;
      end
      r.right_duty    = duty_of(pid_acc[0]);
      r.right_forward = pid_acc[0] > 0;
      r.left_duty     = duty_of(pid_acc[1]);
      r.left_forward  = !(pid_acc[1] > 0);
    end
    r.brake_fired = fired;
    return 1'b1;
  endfunction

  function automatic in_item_t mk_tick(logic [11:0] rc, logic [11:0] lc);
    in_item_t it;
    it = '0;
    it.right_count = rc;
    it.left_count = lc;
    return it;
  endfunction

  function automatic in_item_t mk_cmd(bit w, logic [31:0] tv, logic [31:0] td,
                                      logic [30:0] bd, logic [31:0] bv, bit arm);
    in_item_t it;
    it = in_item_t'{1'b1, w, 12'($urandom), 12'($urandom), tv, td, bd, bv, arm};
    return it;
  endfunction

  // Offers one transaction and updates the model when it is accepted.
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    if (idle_en && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    if (predict_duty(it, r)) duty_q.push_back(typed ? want : r);
  endtask

  // Stops offering and waits until every expected result has come.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (duty_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROP:  kp = val;
      REG_INTEG: ki = val;
      REG_DERIV: kd = val;
      REG_ACCEL: accel = val[9:0];
      REG_EN:    drive_en = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // A tick whose counts follow a plausible wheel speed, with rare outliers.
  function automatic in_item_t plausible_tick();
    int sr, sl;
    sr = $urandom_range(0, 60);
    sl = $urandom_range(0, 60);
    if ($urandom_range(9) == 0) return mk_tick(12'($urandom), 12'($urandom));
    return mk_tick(($urandom_range(1) ? 12'(sr) : 12'((COUNT_WRAP - sr) % COUNT_WRAP)),
                   ($urandom_range(1) ? 12'(sl) : 12'((COUNT_WRAP - sl) % COUNT_WRAP)));
  endfunction

  // A move command with a reachable distance and a brake that is usually armed.
  function automatic in_item_t plausible_cmd(bit w);
    logic [31:0] tv, td, bv;
    logic [30:0] bd;
    if ($urandom_range(9) == 0)
      return mk_cmd(w, $urandom, $urandom, 31'($urandom), $urandom, 1'($urandom));
    tv = 32'($signed($urandom_range(0, 1600)) - 800) <<< 12;
    td = 32'($signed($urandom_range(0, 400)) - 200) <<< 12;
    bd = 31'($urandom_range(0, 60)) <<< 12;
    bv = 32'($signed($urandom_range(0, 200)) - 100) <<< 12;
    return mk_cmd(w, tv, td, bd, bv, $urandom_range(9) != 0);
  endfunction

  // Scoreboard.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (out_valid && out_ready) begin
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", out_data);
      end else begin
        exp_r = duty_q.pop_front();
        if (out_data.right_duty !== exp_r.right_duty ||
            out_data.right_forward !== exp_r.right_forward ||
            out_data.left_duty !== exp_r.left_duty ||
            out_data.left_forward !== exp_r.left_forward ||
            out_data.brake_fired !== exp_r.brake_fired) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, out_data);
        end
      end
    end
  end

  // Receiver stall control with its own count for a long hold.
  always @(posedge clk_i) begin
    if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99) < 17);
    end
  end

  // Ends a run in which no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    out_item_t idle_out;

    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: after reset, count extremes, brake priority, extremes.
    idle_out = '0;
    idle_out.left_forward = 1'b1;
    row.typed = 1'b1; row.want = idle_out; row.item = mk_tick(12'd0, 12'd0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.want = '0;
    row.item = mk_tick(12'd1024, 12'd1025);  rows.push_back(row);
    row.item = mk_tick(12'd2048, 12'd1);     rows.push_back(row);
    row.item = mk_tick(12'd4095, 12'd2049);  rows.push_back(row);
    row.item = mk_cmd(1'b1, 32'sd409600, 32'sd40960, 31'd409600, 32'sd0, 1'b1);
    rows.push_back(row);
    row.item = mk_cmd(1'b0, 32'sd204800, 32'sd4096000, 31'd0, -32'sd4096, 1'b1);
    rows.push_back(row);
    row.item = mk_tick(12'd10, 12'd10);      rows.push_back(row);
    row.item = mk_tick(12'd10, 12'd10);      rows.push_back(row);
    row.item = mk_cmd(1'b0, 32'sd0, 32'sd0, 31'h7fff_ffff, 32'sd8192, 1'b1);
    rows.push_back(row);
    row.item = mk_tick(12'd0, 12'd0);        rows.push_back(row);
    row.item = mk_tick(12'd0, 12'd0);        rows.push_back(row);
    row.item = mk_cmd(1'b0, 32'h7fff_ffff, 32'h8000_0000, 31'd0, 32'h8000_0000, 1'b0);
    rows.push_back(row);
    row.item = mk_cmd(1'b1, 32'h8000_0000, 32'h7fff_ffff, 31'd0, 32'h7fff_ffff, 1'b0);
    rows.push_back(row);
    for (int i = 0; i < 6; i++) begin
      row.item = mk_tick(12'hfff, 12'h000);  rows.push_back(row);
    end
    row.item = mk_cmd(1'b1, 32'sd0, 32'sd0, 31'd0, 32'sd0, 1'b0);
    rows.push_back(row);
    row.item = mk_cmd(1'b0, 32'sd0, 32'sd0, 31'd0, 32'sd0, 1'b0);
    rows.push_back(row);
    row.item = mk_tick(12'h555, 12'haaa);    rows.push_back(row);
    row.item = mk_tick(12'haaa, 12'h555);    rows.push_back(row);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
    drain();

    // Random phases, most of them under a register setting of their own.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_PROP, 32'hffff_ffff); write_reg(REG_INTEG, 32'hffff_ffff);
          write_reg(REG_DERIV, 32'hffff_ffff); write_reg(REG_ACCEL, 32'd1023);
        end
        2: begin
          write_reg(REG_PROP, 32'd0); write_reg(REG_INTEG, 32'd0);
          write_reg(REG_DERIV, 32'd0); write_reg(REG_ACCEL, 32'd0);
        end
        3: write_reg(REG_EN, 32'd0);
        4: begin
          write_reg(REG_EN, 32'd1); write_reg(REG_PROP, 32'd16777216);
          write_reg(REG_INTEG, 32'd100000); write_reg(REG_DERIV, 32'd4000000);
          write_reg(REG_ACCEL, 32'd200);
        end
        5: begin
          write_reg(REG_PROP, $urandom); write_reg(REG_INTEG, $urandom);
          write_reg(REG_DERIV, $urandom); write_reg(REG_ACCEL, $urandom_range(0, 1023));
        end
        6: begin
          write_reg(REG_PROP, 32'd10066330); write_reg(REG_INTEG, 32'd336);
          write_reg(REG_DERIV, 32'd10905190); write_reg(REG_ACCEL, 32'd5);
        end
        default: ;
      endcase
      idle_en = (ph != 4);
      if (ph == 2) hold_reqs++;
      for (int b = 0; b < 8; b++) begin
        send_item(plausible_cmd(1'b0));
        send_item(plausible_cmd(1'b1));
        repeat ($urandom_range(10, 30)) send_item(plausible_tick());
      end
      // The sender pauses here until every result is back.
      drain();
    end

    drain();
    if (mismatches == 0 && duty_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dwvp_pkg.sv
hdl/dual_wheel_velocity_pid.sv
sim/tb_top.sv
